// ===== rtl/core/glmrs_pkg.sv =====
`default_nettype none

package glmrs_pkg;

  localparam int unsigned PIX_W  = 4;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned RISK_W = 18;
  localparam int unsigned CNT_W  = 15;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  localparam logic [RISK_W-1:0] RISK_MAX  = 18'h3FFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 15'h7FFF;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd100;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd100;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // one line memory entry: the row two up and the row one up at a column
  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] prev;
  } line_word_t;

  // position of a pixel within the frame
  typedef struct packed {
    logic col_ge1;
    logic col_ge2;
    logic row_ge1;
    logic row_ge2;
    logic row_end;
    logic last_row;
  } pos_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/glmrs_cfg_regs.sv =====
`default_nettype none

module glmrs_cfg_regs #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned SW = (CW > HW) ? ((CW > 8) ? CW : 8) : ((HW > 8) ? HW : 8)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [glmrs_pkg::APB_AW-1:0]     paddr,
  input  wire logic [glmrs_pkg::APB_DW-1:0]     pwdata,
  output logic      [glmrs_pkg::APB_DW-1:0]     prdata,
  output logic                                  pready,
  output logic      [CW-1:0]                    width_o,
  output logic      [HW-1:0]                    height_o
);

  logic [glmrs_pkg::CFG_W-1:0] width_q, width_d;
  logic [glmrs_pkg::CFG_W-1:0] height_q, height_d;
  glmrs_pkg::reg_idx_e         reg_idx;
  logic                        wr_en;
  logic [SW-1:0]               width_ext, height_ext;

  assign pready  = 1'b1;
  assign reg_idx = glmrs_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_idx)
        glmrs_pkg::REG_FRAME_WIDTH:  width_d  = pwdata[glmrs_pkg::CFG_W-1:0];
        glmrs_pkg::REG_FRAME_HEIGHT: height_d = pwdata[glmrs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= glmrs_pkg::FRAME_WIDTH_RST;
      height_q <= glmrs_pkg::FRAME_HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (reg_idx)
      glmrs_pkg::REG_FRAME_WIDTH:
        prdata = {{(glmrs_pkg::APB_DW-glmrs_pkg::CFG_W){1'b0}}, width_q};
      glmrs_pkg::REG_FRAME_HEIGHT:
        prdata = {{(glmrs_pkg::APB_DW-glmrs_pkg::CFG_W){1'b0}}, height_q};
      default: prdata = '0;
    endcase
  end

  // zero acts as one, oversize saturates
  assign width_ext  = SW'(width_q);
  assign height_ext = SW'(height_q);

  always_comb begin
    if (width_ext == '0) begin
      width_o = CW'(1);
    end else if (width_ext > SW'(MAX_WIDTH)) begin
      width_o = CW'(MAX_WIDTH);
    end else begin
      width_o = CW'(width_ext);
    end
    if (height_ext == '0) begin
      height_o = HW'(1);
    end else if (height_ext > SW'(MAX_HEIGHT)) begin
      height_o = HW'(MAX_HEIGHT);
    end else begin
      height_o = HW'(height_ext);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/glmrs_line_mem.sv =====
`default_nettype none

module glmrs_line_mem #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire glmrs_pkg::line_word_t wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr0_i,
  input  wire logic [AW-1:0]         raddr1_i,
  output glmrs_pkg::line_word_t      rdata0_o,
  output glmrs_pkg::line_word_t      rdata1_o
);

  glmrs_pkg::line_word_t mem_q [DEPTH];
  glmrs_pkg::line_word_t rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

// ===== rtl/core/glmrs_eval.sv =====
`default_nettype none

module glmrs_eval (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              fire_i,
  input  wire glmrs_pkg::pos_flags_t             flags_i,
  input  wire logic [glmrs_pkg::PIX_W-1:0]       px_i,
  input  wire glmrs_pkg::line_word_t             cur_i,
  input  wire logic [glmrs_pkg::PIX_W-1:0]       right_i,
  output logic      [glmrs_pkg::RISK_W-1:0]      risk_o,
  output logic      [glmrs_pkg::CNT_W-1:0]       count_o
);

  localparam int unsigned PW = glmrs_pkg::PIX_W;

  // true when the neighbour is absent or strictly higher than the centre
  function automatic logic beats(logic present, logic [PW-1:0] nb, logic [PW-1:0] c);
    return !present || (c < nb);
  endfunction

  logic [PW-1:0] left1_q;   // pixel one column left, this row
  logic [PW-1:0] left2_q;   // pixel two columns left, this row
  logic [PW-1:0] upleft_q;  // row above, one column left
  logic [glmrs_pkg::RISK_W-1:0] risk_q;
  logic [glmrs_pkg::CNT_W-1:0]  cnt_q;

  logic          low_up, low_left, low_here;
  logic          frame_end;
  logic [PW+1:0] add_risk;
  logic [1:0]    add_cnt;
  logic [glmrs_pkg::RISK_W:0] risk_sum;
  logic [glmrs_pkg::CNT_W:0]  cnt_sum;

  assign frame_end = flags_i.row_end && flags_i.last_row;

  always_comb begin
    // centre one row up, its lower neighbour is the incoming pixel
    low_up = flags_i.row_ge1
          && beats(flags_i.col_ge1, upleft_q, cur_i.prev)
          && beats(!flags_i.row_end, right_i, cur_i.prev)
          && beats(flags_i.row_ge2, cur_i.older, cur_i.prev)
          && (cur_i.prev < px_i);
    // last row: centre one column left, its right neighbour has arrived
    low_left = flags_i.last_row && flags_i.col_ge1
            && beats(flags_i.col_ge2, left2_q, left1_q)
            && (left1_q < px_i)
            && beats(flags_i.row_ge1, upleft_q, left1_q);
    // last pixel of the frame
    low_here = frame_end
            && beats(flags_i.col_ge1, left1_q, px_i)
            && beats(flags_i.row_ge1, cur_i.prev, px_i);

    add_risk = (low_up   ? ((PW+2)'(cur_i.prev) + 1'b1) : '0)
             + (low_left ? ((PW+2)'(left1_q)    + 1'b1) : '0)
             + (low_here ? ((PW+2)'(px_i)       + 1'b1) : '0);
    add_cnt  = 2'(low_up) + 2'(low_left) + 2'(low_here);

    risk_sum = {1'b0, risk_q} + (glmrs_pkg::RISK_W+1)'(add_risk);
    cnt_sum  = {1'b0, cnt_q}  + (glmrs_pkg::CNT_W+1)'(add_cnt);
    risk_o   = risk_sum[glmrs_pkg::RISK_W] ? glmrs_pkg::RISK_MAX
                                           : risk_sum[glmrs_pkg::RISK_W-1:0];
    count_o  = cnt_sum[glmrs_pkg::CNT_W] ? glmrs_pkg::COUNT_MAX
                                         : cnt_sum[glmrs_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      risk_q <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      risk_q <= frame_end ? '0 : risk_o;
      cnt_q  <= frame_end ? '0 : count_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      left2_q  <= left1_q;
      left1_q  <= px_i;
      upleft_q <= cur_i.prev;
    end
  end

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && frame_end |=> risk_q == '0 && cnt_q == '0)
    else $error("totals not cleared after frame end");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !frame_end |=> cnt_q >= $past(cnt_q) && risk_q >= $past(risk_q))
    else $error("running totals decreased within a frame");

endmodule

`default_nettype wire

// ===== rtl/core/grid_local_minimum_risk_sum.sv =====
`default_nettype none

// Four-neighbour low point finder over a streamed height frame. Pixels enter
// in raster order, one transaction per pixel, and every pixel gives exactly one
// result transaction carrying the running risk total (height plus one summed
// over low points so far), the low point count and frame_done on the frame's
// last pixel, after which the totals clear. The block takes one pixel per
// cycle when the output side keeps up; a taken pixel waits in the read stage
// for the registered line memory read, then its result is registered. The line
// memory holds the two earlier rows, one entry per column, and is read at the
// current and the next column while the previous pixel's entry is written;
// same-entry overlap is covered by forwarding. The line memory has no reset
// and needs no clearing pass: a new frame only uses entries it has already
// written. Frame size is set over the APB port (frame_width at 0x0,
// frame_height at 0x4); zero acts as one and sizes above the maxima saturate.
// Change the size only while the block is idle.
module grid_local_minimum_risk_sum #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [glmrs_pkg::APB_AW-1:0]      paddr,
  input  wire logic [glmrs_pkg::APB_DW-1:0]      pwdata,
  output logic      [glmrs_pkg::APB_DW-1:0]      prdata,
  output logic                                   pready,
  // pixel input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [glmrs_pkg::PIX_W-1:0]       height_value_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [glmrs_pkg::RISK_W-1:0]      risk_total_o,
  output logic      [glmrs_pkg::CNT_W-1:0]       low_point_count_o,
  output logic                                   frame_done_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = glmrs_pkg::PIX_W;

  // effective frame size
  logic [CW-1:0] width_eff;
  logic [HW-1:0] height_eff;

  // position counters for the next pixel
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  glmrs_pkg::pos_flags_t flags;
  logic [AW-1:0] rd_addr1;
  logic          in_accept;

  // read stage: pixel waiting for its line memory data
  logic                  s1_valid_q, s1_valid_d;
  logic [PW-1:0]         s1_px_q;
  logic [AW-1:0]         s1_col_q;
  glmrs_pkg::pos_flags_t s1_flags_q;
  logic                  s1_fire;

  // forwarding of the entry written in the same cycle as the read
  logic                  fwd0_hit_q, fwd1_hit_q;
  glmrs_pkg::line_word_t fwd0_word_q;
  logic [PW-1:0]         fwd1_px_q;

  // line memory
  glmrs_pkg::line_word_t rdata0, rdata1, cur_word, wr_word;
  logic [PW-1:0]         right_px;

  // result register
  logic                         out_valid_q;
  logic [glmrs_pkg::RISK_W-1:0] risk_q, risk_next;
  logic [glmrs_pkg::CNT_W-1:0]  cnt_q, cnt_next;
  logic                         done_q;

  glmrs_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width_eff),
    .height_o (height_eff)
  );

  // position flags of the incoming pixel
  always_comb begin
    flags.col_ge1  = (col_q != '0);
    flags.col_ge2  = (col_q > AW'(1));
    flags.row_ge1  = (row_q != '0);
    flags.row_ge2  = (row_q > RW'(1));
    // counters at or past a shrunk size also end the row or frame
    flags.row_end  = ((CW'(col_q) + CW'(1)) >= width_eff);
    flags.last_row = ((HW'(row_q) + HW'(1)) >= height_eff);
  end

  // right-hand neighbour column, only used when the row goes on
  assign rd_addr1 = (col_q == AW'(MAX_WIDTH - 1)) ? '0 : (col_q + AW'(1));

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (flags.row_end) begin
        col_d = '0;
        row_d = flags.last_row ? '0 : (row_q + RW'(1));
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd0_hit_q <= 1'b0;
      fwd1_hit_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (in_accept) begin
        fwd0_hit_q <= s1_fire && (col_q == s1_col_q);
        fwd1_hit_q <= s1_fire && (rd_addr1 == s1_col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q     <= height_value_i;
      s1_col_q    <= col_q;
      s1_flags_q  <= flags;
      fwd0_word_q <= wr_word;
      fwd1_px_q   <= s1_px_q;
    end
  end

  // the row one up moves to the older slot, the new pixel takes its place
  assign cur_word = fwd0_hit_q ? fwd0_word_q : rdata0;
  assign right_px = fwd1_hit_q ? fwd1_px_q : rdata1.prev;
  assign wr_word  = '{older: cur_word.prev, prev: s1_px_q};

  glmrs_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i    (clk_i),
    .we_i     (s1_fire),
    .waddr_i  (s1_col_q),
    .wdata_i  (wr_word),
    .re_i     (in_accept),
    .raddr0_i (col_q),
    .raddr1_i (rd_addr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  glmrs_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_fire),
    .flags_i (s1_flags_q),
    .px_i    (s1_px_q),
    .cur_i   (cur_word),
    .right_i (right_px),
    .risk_o  (risk_next),
    .count_o (cnt_next)
  );

  // result register, refilled while the old result is being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      risk_q <= risk_next;
      cnt_q  <= cnt_next;
      done_q <= s1_flags_q.row_end && s1_flags_q.last_row;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign risk_total_o      = risk_q;
  assign low_point_count_o = cnt_q;
  assign frame_done_o      = done_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!s1_valid_q || s1_fire))
    else $error("pixel taken while the read stage is blocked");

  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("evaluated pixel gave no result");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && flags.row_end |=> col_q == '0)
    else $error("column counter did not wrap at row end");

endmodule

`default_nettype wire
